// ===== rtl/psc_pkg.sv =====
// psc_pkg: shared widths, constants and helpers of the prime sieve counter
// no dependencies; used by the interfaces and every module under rtl
package psc_pkg;

    localparam int CFG_W          = 16;
    localparam int CNT_W          = 16;
    localparam int MAX_LIMIT_DEF  = 65535;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 16'hffff;

    localparam logic [7:0] FIRST_BYTE = 8'h3f;
    localparam logic [7:0] FULL_BYTE  = 8'hff;
    localparam logic [7:0] TOP_BIT    = 8'h80;
    localparam int         FIRST_PRIME = 2;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] acc;
        acc = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            acc = acc + {3'd0, v[i]};
        end
        return acc;
    endfunction

endpackage

// ===== rtl/psc_if.sv =====
// psc_if: valid/ready channels of the prime sieve counter
// depends on psc_pkg for payload widths
interface psc_start_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink (input valid, input start_req, output ready);
endinterface

interface psc_count_if;
    logic                       valid;
    logic                       ready;
    logic [psc_pkg::CNT_W-1:0]  prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink (input valid, input prime_count, output ready);
endinterface

// ===== rtl/psc_store.sv =====
// psc_store: sieve bit store, one byte per eight numbers, registered read
// depends on psc_pkg
module psc_store #(
    parameter int ADDR_W = 13,
    parameter int DEPTH  = 8192
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    import psc_pkg::*;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/psc_seq.sv =====
// psc_seq: sequencer for fill, strike, prime search and count phases
// depends on psc_pkg and psc_if; drives the psc_store ports
module psc_seq #(
    parameter int MAX_LIMIT = psc_pkg::MAX_LIMIT_DEF,
    parameter int NUM_W     = $clog2(MAX_LIMIT + 1),
    parameter int ADDR_W    = NUM_W - 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [psc_pkg::CFG_W-1:0] sieve_limit,
    psc_start_if.sink                 start,
    psc_count_if.source               result,
    output logic                      st_we,
    output logic [ADDR_W-1:0]         st_waddr,
    output logic [7:0]                st_wdata,
    output logic                      st_re,
    output logic [ADDR_W-1:0]         st_raddr,
    input  logic [7:0]                st_rdata
);
    import psc_pkg::*;

    localparam int P_W  = NUM_W + 1;
    localparam int SQ_W = 2 * P_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILL   = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_S_RD   = 4'd3;
    localparam logic [3:0] ST_S_WR   = 4'd4;
    localparam logic [3:0] ST_SR_RD  = 4'd5;
    localparam logic [3:0] ST_SR_CHK = 4'd6;
    localparam logic [3:0] ST_C_RD   = 4'd7;
    localparam logic [3:0] ST_C_ACC  = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [NUM_W-1:0]  lim_reg, lim_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [P_W-1:0]    m_reg, m_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic [ADDR_W-1:0] lim_byte;
    logic [31:0]       lim_wide;
    logic [7:0]        cnt_mask;
    logic [SQ_W-1:0]   sq_step;
    logic              start_fire;

    assign lim_byte   = lim_reg[NUM_W-1:3];
    assign lim_wide   = (32'(sieve_limit) > 32'(MAX_LIMIT)) ? 32'(MAX_LIMIT) : 32'(sieve_limit);
    assign cnt_mask   = (addr_reg == lim_byte) ? (FULL_BYTE << (3'd7 - lim_reg[2:0])) : FULL_BYTE;
    assign sq_step    = sq_reg + SQ_W'({p_reg, 1'b1});
    assign start_fire = start.valid && start.ready;

    assign start.ready        = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.prime_count = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        lim_next       = lim_reg;
        addr_next      = addr_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        m_next         = m_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_count_next = out_count_reg;
        st_we          = 1'b0;
        st_waddr       = addr_reg;
        st_wdata       = FULL_BYTE;
        st_re          = 1'b0;
        st_raddr       = addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start_fire && start.start_req)
                begin
                    lim_next   = lim_wide[NUM_W-1:0];
                    addr_next  = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                st_we    = 1'b1;
                st_waddr = addr_reg;
                st_wdata = (addr_reg == '0) ? FIRST_BYTE : FULL_BYTE;
                if (addr_reg == lim_byte)
                begin
                    p_next     = P_W'(FIRST_PRIME);
                    sq_next    = SQ_W'(FIRST_PRIME * FIRST_PRIME);
                    state_next = ST_CHECK;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > SQ_W'(lim_reg))
                begin
                    addr_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_C_RD;
                end
                else
                begin
                    m_next     = {p_reg[P_W-2:0], 1'b0};
                    state_next = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                if (m_reg > P_W'(lim_reg))
                begin
                    p_next     = p_reg + 1'b1;
                    sq_next    = sq_step;
                    state_next = ST_SR_RD;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = m_reg[NUM_W-1:3];
                    state_next = ST_S_WR;
                end
            end
            ST_S_WR:
            begin
                st_we      = 1'b1;
                st_waddr   = m_reg[NUM_W-1:3];
                st_wdata   = st_rdata & ~(TOP_BIT >> m_reg[2:0]);
                m_next     = m_reg + p_reg;
                state_next = ST_S_RD;
            end
            ST_SR_RD:
            begin
                if (p_reg > P_W'(lim_reg))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = p_reg[NUM_W-1:3];
                    state_next = ST_SR_CHK;
                end
            end
            ST_SR_CHK:
            begin
                if ((st_rdata & (TOP_BIT >> p_reg[2:0])) != 8'd0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    sq_next    = sq_step;
                    state_next = ST_SR_RD;
                end
            end
            ST_C_RD:
            begin
                st_re      = 1'b1;
                st_raddr   = addr_reg;
                state_next = ST_C_ACC;
            end
            ST_C_ACC:
            begin
                cnt_next = cnt_reg + CNT_W'(popcount8(st_rdata & cnt_mask));
                if (addr_reg == lim_byte)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_C_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        addr_reg      <= addr_next;
        sq_reg        <= sq_next;
        m_reg         <= m_next;
        cnt_reg       <= cnt_next;
        out_count_reg <= out_count_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !start.ready)
        else $error("start accepted while a run is in progress");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (st_waddr <= lim_byte))
        else $error("store write beyond the limit byte");

    a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (sq_reg == SQ_W'(p_reg) * SQ_W'(p_reg)))
        else $error("square of current prime out of step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

// ===== rtl/prime_sieve_counter.sv =====
// prime_sieve_counter: top level, limit register, sequencer and bit store
// depends on psc_pkg, psc_if, psc_store and psc_seq
//
// usage:
//   start  - sink channel; a beat with start_req = 1 runs one sieve over
//            0..sieve_limit, a beat with start_req = 0 is taken and dropped
//   result - source channel; one beat carrying prime_count per run
//   cfg_we / cfg_data - writes sieve_limit (saturated to MAX_LIMIT per run)
// work at limit L, B = L/8 + 1 bytes:
//   fill writes each of the B bytes, count reads and sums each byte,
//   strike reads and rewrites the byte of each struck multiple, and
//   the prime search reads the byte of each probed candidate;
//   start is ready only while idle; one run at a time
// reset: sequencer idle, no result pending, limit back to 65535;
//   the store itself is not cleared, a run writes every byte it reads
// a stalled result holds in the output register; the next run ends in
//   the done state and waits there until that beat drains
module prime_sieve_counter #(
    parameter int MAX_LIMIT = psc_pkg::MAX_LIMIT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [psc_pkg::CFG_W-1:0] cfg_data,
    psc_start_if.sink                 start,
    psc_count_if.source               result
);
    import psc_pkg::*;

    localparam int NUM_W       = $clog2(MAX_LIMIT + 1);
    localparam int ADDR_W      = NUM_W - 3;
    localparam int STORE_BYTES = (MAX_LIMIT / 8) + 1;

    logic [CFG_W-1:0]  limit_reg;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [7:0]        st_wdata;
    logic              st_re;
    logic [ADDR_W-1:0] st_raddr;
    logic [7:0]        st_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    psc_seq #(
        .MAX_LIMIT (MAX_LIMIT),
        .NUM_W     (NUM_W),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .sieve_limit (limit_reg),
        .start       (start),
        .result      (result),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata),
        .st_re       (st_re),
        .st_raddr    (st_raddr),
        .st_rdata    (st_rdata)
    );

    psc_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

endmodule
